// ----- src/tsc_pkg.sv -----
package tsc_pkg;

   localparam int OutWidth = 48;
   localparam int SelWidth = 4;

   // count_select bits
   localparam int SelLines  = 0;
   localparam int SelWords  = 1;
   localparam int SelBytes  = 2;
   localparam int SelMaxLen = 3;

   localparam logic [SelWidth-1:0] SelReset   = 4'd7;
   localparam logic [SelWidth-1:0] SelDefault = 4'd7;

   localparam logic [7:0] ChrTab     = 8'h09;
   localparam logic [7:0] ChrNewline = 8'h0A;
   localparam logic [7:0] ChrVt      = 8'h0B;
   localparam logic [7:0] ChrFf      = 8'h0C;
   localparam logic [7:0] ChrCr      = 8'h0D;
   localparam logic [7:0] ChrSpace   = 8'h20;
   localparam logic [7:0] ChrPrintLo = 8'h21;
   localparam logic [7:0] ChrPrintHi = 8'h7E;

   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = 2;
   localparam int QueueCntWidth = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [OutWidth-1:0] line_count;
      logic [OutWidth-1:0] word_count;
      logic [OutWidth-1:0] byte_count;
      logic [OutWidth-1:0] max_line_width;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_BYTE,      // byte counted only, scanning off
      CLS_NEWLINE,
      CLS_LINE_END,  // cr or ff
      CLS_TAB,
      CLS_SPACE,
      CLS_VT,
      CLS_PRINT,     // printable word character
      CLS_NONPRINT   // non-printing word character
   } cls_type;

   typedef struct packed {
      logic                is_end;
      cls_type             cls;
      logic [SelWidth-1:0] sel;
   } qitem_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- src/tsc_front.sv -----
module tsc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsc_pkg::SelWidth-1:0]   csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tsc_pkg::req_type               req_payload,
   output logic                           push_valid,
   input  logic                           push_ready,
   output tsc_pkg::qitem_type             push_item
);
   import tsc_pkg::*;

   logic [SelWidth-1:0] count_select_ff, count_select_in;
   logic                valid_ff, valid_in;
   qitem_type           item_ff, item_in;
   logic [SelWidth-1:0] eff_sel;
   logic                scan_en;
   logic                req_accept;
   logic [7:0]          c;

   assign csr_ready       = 1'b1;
   assign count_select_in = (csr_valid && csr_ready) ? csr_data : count_select_ff;

   assign req_ready  = !valid_ff || push_ready;
   assign req_accept = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   assign eff_sel = (count_select_ff == '0) ? SelDefault : count_select_ff;
   assign scan_en = eff_sel[SelLines] || eff_sel[SelWords] || eff_sel[SelMaxLen];
   assign c       = req_payload.data_byte;

   always_comb begin
      item_in.is_end = req_payload.end_of_stream;
      item_in.sel    = eff_sel;
      item_in.cls    = CLS_BYTE;
      if (scan_en && !req_payload.end_of_stream) begin
         unique case (c)
            ChrNewline:    item_in.cls = CLS_NEWLINE;
            ChrCr, ChrFf:  item_in.cls = CLS_LINE_END;
            ChrTab:        item_in.cls = CLS_TAB;
            ChrSpace:      item_in.cls = CLS_SPACE;
            ChrVt:         item_in.cls = CLS_VT;
            default: begin
               if (c >= ChrPrintLo && c <= ChrPrintHi) item_in.cls = CLS_PRINT;
               else                                    item_in.cls = CLS_NONPRINT;
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept)      valid_in = 1'b1;
      else if (push_ready) valid_in = 1'b0;
      else                 valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_select_ff <= SelReset;
         valid_ff        <= 1'b0;
      end else begin
         count_select_ff <= count_select_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) item_ff <= item_in;
   end

endmodule

// ----- src/tsc_queue.sv -----
module tsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsc_pkg::qitem_type   push_item,
   input  logic                 pop,
   output tsc_pkg::qitem_type   head_item,
   output tsc_pkg::qstat_type   stat
);
   import tsc_pkg::*;

   qitem_type                entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == QueueCntWidth'(QueueDepth));
   assign stat.empty = (count_ff == '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ----- src/tsc_back.sv -----
module tsc_back #(
   parameter int COUNT_WIDTH = 48,
   parameter int TAB_STOP    = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tsc_pkg::qitem_type   head_item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tsc_pkg::rsp_type     rsp_payload
);
   import tsc_pkg::*;

   localparam int ModWidth     = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int StepWidth    = $clog2(TAB_STOP + 1);
   localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

   logic [COUNT_WIDTH-1:0] col_ff, col_in;
   logic [ModWidth-1:0]    col_mod_ff, col_mod_in;
   logic                   in_word_ff, in_word_in;
   logic [COUNT_WIDTH-1:0] lines_ff, lines_in;
   logic [COUNT_WIDTH-1:0] words_ff, words_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   logic [COUNT_WIDTH-1:0] widest_ff, widest_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   out_free;
   logic [COUNT_WIDTH-1:0] widest_now;
   logic [StepWidth-1:0]   tab_step;
   logic [COUNT_WIDTH:0]   tab_sum;
   logic [COUNT_WIDTH-1:0] col_inc;
   logic [ModWidth-1:0]    mod_inc;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
      return (x == CntMax) ? x : x + 1'b1;
   endfunction

   function automatic logic [OutWidth-1:0] to_out(input logic [COUNT_WIDTH-1:0] x,
                                                  input logic sel);
      logic [63:0] w;
      w = 64'(x);
      return sel ? w[OutWidth-1:0] : '0;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = head_valid && (!head_item.is_end || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign widest_now = (col_ff > widest_ff) ? col_ff : widest_ff;
   assign col_inc    = sat_inc(col_ff);
   assign mod_inc    = (col_mod_ff == ModWidth'(TAB_STOP - 1)) ? '0 : col_mod_ff + 1'b1;
   // distance to next tab stop, tracked through the column phase counter
   assign tab_step   = StepWidth'(TAB_STOP) - StepWidth'(col_mod_ff);
   assign tab_sum    = {1'b0, col_ff} + (COUNT_WIDTH + 1)'(tab_step);

   always_comb begin
      col_in     = col_ff;
      col_mod_in = col_mod_ff;
      in_word_in = in_word_ff;
      lines_in   = lines_ff;
      words_in   = words_ff;
      bytes_in   = bytes_ff;
      widest_in  = widest_ff;
      rsp_in     = rsp_ff;
      if (pop) begin
         if (head_item.is_end) begin
            rsp_in.line_count     = to_out(lines_ff, head_item.sel[SelLines]);
            rsp_in.word_count     = to_out(words_ff, head_item.sel[SelWords]);
            rsp_in.byte_count     = to_out(bytes_ff, head_item.sel[SelBytes]);
            rsp_in.max_line_width = to_out(widest_now, head_item.sel[SelMaxLen]);
            col_in     = '0;
            col_mod_in = '0;
            in_word_in = 1'b0;
            lines_in   = '0;
            words_in   = '0;
            bytes_in   = '0;
            widest_in  = '0;
         end else begin
            bytes_in = sat_inc(bytes_ff);
            unique case (head_item.cls)
               CLS_BYTE: ;
               CLS_NEWLINE, CLS_LINE_END: begin
                  if (head_item.cls == CLS_NEWLINE) lines_in = sat_inc(lines_ff);
                  widest_in  = widest_now;
                  col_in     = '0;
                  col_mod_in = '0;
                  in_word_in = 1'b0;
               end
               CLS_TAB: begin
                  col_in     = tab_sum[COUNT_WIDTH] ? CntMax : tab_sum[COUNT_WIDTH-1:0];
                  col_mod_in = '0;
                  in_word_in = 1'b0;
               end
               CLS_SPACE: begin
                  col_in     = col_inc;
                  col_mod_in = mod_inc;
                  in_word_in = 1'b0;
               end
               CLS_VT: in_word_in = 1'b0;
               CLS_PRINT, CLS_NONPRINT: begin
                  if (head_item.cls == CLS_PRINT) begin
                     col_in     = col_inc;
                     col_mod_in = mod_inc;
                  end
                  if (!in_word_ff) words_in = sat_inc(words_ff);
                  in_word_in = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (pop && head_item.is_end) rsp_valid_in = 1'b1;
      else if (rsp_ready)          rsp_valid_in = 1'b0;
      else                         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         col_mod_ff   <= '0;
         in_word_ff   <= 1'b0;
         lines_ff     <= '0;
         words_ff     <= '0;
         bytes_ff     <= '0;
         widest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         col_mod_ff   <= col_mod_in;
         in_word_ff   <= in_word_in;
         lines_ff     <= lines_in;
         words_ff     <= words_in;
         bytes_ff     <= bytes_in;
         widest_ff    <= widest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- src/text_stream_counter_unit.sv -----
// text_stream_counter_unit: counts bytes, newlines, words and the widest
// line's display width of a byte stream, in the manner of a word count utility.
// req channel: one item per byte (data_byte), or an end item
// (end_of_stream = 1) that returns the counts on rsp and clears all counts.
// rsp channel: one item per end item, with the four counts; a count whose
// count_select bit is clear reads as zero. Counters saturate.
// csr channel: writes count_select; always ready. Write it only while no
// item is in flight.
// Throughput: one item per cycle, set by the counter update in the back
// end, while no end item waits on a stalled rsp. The result of an end item
// passes through the front register, then the four-entry queue and the
// counter update into the output register.
// Reset clears all counts and sets count_select to lines+words+bytes.
// When rsp is stalled, byte items ahead of an end item keep flowing; an end
// item waits in the queue until the output register frees, and req_ready
// drops once the queue and the front register are full.
module text_stream_counter_unit #(
   parameter int COUNT_WIDTH = 48,
   parameter int TAB_STOP    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tsc_pkg::SelWidth-1:0] csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tsc_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tsc_pkg::rsp_type             rsp_payload
);
   import tsc_pkg::*;

   logic      push_valid;
   logic      push;
   logic      pop;
   qitem_type push_item;
   qitem_type head_item;
   qstat_type q_stat;

   assign push = push_valid && !q_stat.full;

   tsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (!q_stat.full),
      .push_item   (push_item)
   );

   tsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   tsc_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TAB_STOP    (TAB_STOP)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (!q_stat.empty),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full))
      else $error("item pushed into full queue");

   // queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty))
      else $error("item popped from empty queue");

   // a new result only appears after an end item leaves the queue
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop && head_item.is_end))
      else $error("result without end item");

   // an end item is not taken while a stalled result is still held
   a_end_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(pop && head_item.is_end))
      else $error("end item overwrote pending result");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tsc_pkg::*;

   localparam int CountWidth = 48;
   localparam int TabStop = 8;
   localparam longint unsigned CountMax = (64'd1 << CountWidth) - 64'd1;
   localparam int ItemsPerPhase = 130;
   localparam int DrainCycles = 8;
   localparam int CycleLimit = 400000;

   // predicts the counts of each stream and checks them against the block
   class count_board;
      logic [SelWidth-1:0] select_reg;
      longint unsigned col_pos, line_total, word_total, byte_total, widest_col;
      bit in_word;
      rsp_type pending_counts[$];
      int errors;

      function new();
         select_reg = SelReset;
         clear_counts();
         errors = 0;
      endfunction

      function void clear_counts();
         col_pos = 0;
         line_total = 0;
         word_total = 0;
         byte_total = 0;
         widest_col = 0;
         in_word = 0;
      endfunction

      function longint unsigned sat_add(longint unsigned a, longint unsigned b);
         if (a > CountMax || b > CountMax - a) return CountMax;
         return a + b;
      endfunction

      function void close_line();
         if (col_pos > widest_col) widest_col = col_pos;
         col_pos = 0;
         in_word = 0;
      endfunction

      function void note_item(req_type it);
         logic [SelWidth-1:0] sel;
         rsp_type counts;
         sel = (select_reg == '0) ? SelDefault : select_reg;
         if (!it.end_of_stream) begin
            byte_total = sat_add(byte_total, 1);
            // scanning runs only when lines, words or max length is selected
            if (sel[SelLines] || sel[SelWords] || sel[SelMaxLen]) begin
               case (it.data_byte)
                  ChrNewline: begin
                     line_total = sat_add(line_total, 1);
                     close_line();
                  end
                  ChrCr, ChrFf: close_line();
                  ChrTab: begin
                     col_pos = sat_add(col_pos, TabStop - (col_pos % TabStop));
                     in_word = 0;
                  end
                  ChrSpace: begin
                     col_pos = sat_add(col_pos, 1);
                     in_word = 0;
                  end
                  ChrVt: in_word = 0;
                  default: begin
                     if (it.data_byte >= ChrPrintLo && it.data_byte <= ChrPrintHi)
                        col_pos = sat_add(col_pos, 1);
                     if (!in_word) word_total = sat_add(word_total, 1);
                     in_word = 1;
                  end
               endcase
            end
         end else begin
            // the open line counts toward the widest one
            if (col_pos > widest_col) widest_col = col_pos;
            counts.line_count = sel[SelLines] ? line_total[OutWidth-1:0] : '0;
            counts.word_count = sel[SelWords] ? word_total[OutWidth-1:0] : '0;
            counts.byte_count = sel[SelBytes] ? byte_total[OutWidth-1:0] : '0;
            counts.max_line_width = sel[SelMaxLen] ? widest_col[OutWidth-1:0] : '0;
            pending_counts.push_back(counts);
            clear_counts();
         end
      endfunction

      function void compare_field(string name, logic [OutWidth-1:0] want,
                                  logic [OutWidth-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_counts(rsp_type got);
         rsp_type want;
         if (pending_counts.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            return;
         end
         want = pending_counts.pop_front();
         compare_field("line_count", want.line_count, got.line_count);
         compare_field("word_count", want.word_count, got.word_count);
         compare_field("byte_count", want.byte_count, got.byte_count);
         compare_field("max_line_width", want.max_line_width, got.max_line_width);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [SelWidth-1:0] csr_data;
   logic req_valid;
   logic req_ready;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_payload;

   count_board board = new();
   int send_gap_pct;
   int rsp_stall_pct;
   int cycles;

   text_stream_counter_unit #(
      .COUNT_WIDTH(CountWidth),
      .TAB_STOP(TabStop)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 0;
      reset = 1;
      csr_valid = 0;
      csr_data = '0;
      req_valid = 0;
      req_payload = '0;
      rsp_ready = 0;
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      cycles = 0;
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: check accepted items, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_counts(rsp_payload);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // called just after a rising edge; returns in the step of acceptance
   task automatic send_item(logic [7:0] data, logic last);
      req_type it;
      it.data_byte = data;
      it.end_of_stream = last;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(it);
   endtask

   // selection changes only once the block has drained
   task automatic write_select(logic [SelWidth-1:0] value);
      req_valid <= 0;
      @(posedge clock);
      while (board.pending_counts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_valid <= 1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.select_reg = value;
      csr_valid <= 0;
   endtask

   initial begin
      logic [7:0] probe [15] = '{8'h61, 8'h7E, 8'h21, ChrTab, ChrSpace, ChrVt, 8'h41,
                                 ChrNewline, ChrCr, 8'h00, 8'h7F, 8'h80, 8'hFF, ChrFf,
                                 8'h1F};
      int sent;
      int len;
      int r;
      bit noisy;
      logic [7:0] b;

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // every byte class, all counts on
      write_select(4'hF);
      foreach (probe[i]) send_item(probe[i], 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b1);

      // bytes only: scanning off, then switched on mid-stream via zero
      write_select(4'h4);
      send_item(8'h61, 1'b0);
      send_item(ChrSpace, 1'b0);
      send_item(ChrNewline, 1'b0);
      write_select(4'h0);
      send_item(8'h62, 1'b0);
      send_item(ChrTab, 1'b0);
      send_item(ChrNewline, 1'b0);
      send_item(8'h00, 1'b1);

      // width only: tabs from an unaligned column, open line at the end
      write_select(4'h8);
      send_item(8'h63, 1'b0);
      send_item(ChrTab, 1'b0);
      send_item(ChrTab, 1'b0);
      send_item(8'h64, 1'b1);

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0; rsp_stall_pct = 0; end
            1: begin send_gap_pct = 50; rsp_stall_pct = 0; end
            2: begin send_gap_pct = 0; rsp_stall_pct = 50; end
            default: begin send_gap_pct = 11; rsp_stall_pct = 11; end
         endcase
         write_select(SelWidth'($urandom_range(15)));
         while (sent < (phase + 1) * ItemsPerPhase) begin
            if ($urandom_range(7) == 0) write_select(SelWidth'($urandom_range(15)));
            len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(20);
            noisy = ($urandom_range(4) == 0);
            for (int k = 0; k < len; k++) begin
               r = $urandom_range(99);
               if (noisy || r >= 90) b = 8'($urandom_range(255));
               else if (r < 40) b = 8'h61 + 8'($urandom_range(25));
               else if (r < 45) b = 8'h21 + 8'($urandom_range(93));
               else if (r < 60) b = ChrSpace;
               else if (r < 68) b = ChrNewline;
               else if (r < 73) b = ChrTab;
               else if (r < 76) b = ChrCr;
               else if (r < 78) b = ChrFf;
               else if (r < 80) b = ChrVt;
               else if (r < 85) b = 8'($urandom_range(31));
               else b = 8'h7F + 8'($urandom_range(128));
               if ($urandom_range(59) == 0) write_select(SelWidth'($urandom_range(15)));
               send_item(b, 1'b0);
               sent++;
            end
            send_item(8'($urandom_range(255)), 1'b1);
            sent++;
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (board.pending_counts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
